// ----- rtl/pidd_pkg.sv -----
// ============================================================================
// pidd_pkg
// Shared types and constants of the dual-form PID controller core.
// ============================================================================
package pidd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 23;

    // Register map of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_OUTPUT_LIMIT = 3'd3,
        REG_INTEG_LIMIT  = 3'd4,
        REG_FORM_SELECT  = 3'd5,
        REG_INTEG_RST_EN = 3'd6,
        REG_INTEG_RST_TH = 3'd7
    } t_reg_idx;

    localparam logic FORM_INCREMENTAL = 1'b0;
    localparam logic FORM_POSITIONAL  = 1'b1;

    typedef struct packed {
        logic signed [15:0] measured;
        logic signed [15:0] setpoint;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic        [14:0] output_limit;
        logic        [22:0] integral_limit;
        logic               form_select;
        logic               integral_reset_enable;
        logic signed [16:0] integral_reset_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [16:0] prev_error;
        logic signed [16:0] prev_prev_error;
        logic signed [23:0] error_sum;
        logic signed [15:0] held_output;
    } t_pid_state;

    localparam t_cfg CFG_RESET = '{
        gain_p:                   16'sd0,
        gain_i:                   16'sd0,
        gain_d:                   16'sd0,
        output_limit:             15'd32767,
        integral_limit:           23'd8388607,
        form_select:              FORM_POSITIONAL,
        integral_reset_enable:    1'b0,
        integral_reset_threshold: 17'sd65535
    };

    localparam t_pid_state STATE_RESET = '{
        prev_error:      17'sd0,
        prev_prev_error: 17'sd0,
        error_sum:       24'sd0,
        held_output:     16'sd0
    };

endpackage

// ----- rtl/pidd_datapath.sv -----
// ============================================================================
// pidd_datapath
// One control step: error, integral update, gain products and output clamp.
// ============================================================================
module pidd_datapath (
    input  pidd_pkg::t_cfg       i_cfg,
    input  pidd_pkg::t_pid_state i_state,
    input  pidd_pkg::t_in_item   i_item,
    output pidd_pkg::t_pid_state o_state,
    output pidd_pkg::t_out_item  o_result
);

    logic signed [15:0] w_kp, w_ki, w_kd;
    logic signed [16:0] w_err;
    logic signed [17:0] w_d1;
    logic signed [18:0] w_d2;

    // Incremental form products.
    logic signed [33:0] w_prod_p_inc;
    logic signed [32:0] w_prod_i_inc;
    logic signed [34:0] w_prod_d_inc;
    logic signed [41:0] w_v_inc;

    // Positional form integral and products.
    logic signed [24:0] w_acc;
    logic signed [24:0] w_acc_z;
    logic signed [24:0] w_ilim;
    logic signed [24:0] w_acc_c;
    logic signed [23:0] w_esum_new;
    logic signed [32:0] w_prod_p_pos;
    logic signed [39:0] w_prod_i_pos;
    logic signed [33:0] w_prod_d_pos;
    logic signed [41:0] w_v_pos;

    logic signed [41:0] w_v;
    logic signed [41:0] w_olim;
    logic signed [41:0] w_v_c;
    logic               w_hit;

    assign w_kp = i_cfg.gain_p;
    assign w_ki = i_cfg.gain_i;
    assign w_kd = i_cfg.gain_d;

    assign w_err = 17'(i_item.setpoint) - 17'(i_item.measured);
    assign w_d1  = 18'(w_err) - 18'(i_state.prev_error);
    assign w_d2  = 19'(w_err) - (19'(i_state.prev_error) <<< 1)
                 + 19'(i_state.prev_prev_error);

    assign w_prod_p_inc = 34'(w_kp) * 34'(w_d1);
    assign w_prod_i_inc = 33'(w_ki) * 33'(w_err);
    assign w_prod_d_inc = 35'(w_kd) * 35'(w_d2);

    assign w_v_inc = 42'(i_state.held_output)
                   + 42'(w_prod_p_inc >>> 8)
                   + 42'(w_prod_i_inc >>> 8)
                   + 42'(w_prod_d_inc >>> 8);

    // When enabled, the integral is zeroed on an error above the reset threshold before it is clamped.
    assign w_acc   = 25'(i_state.error_sum) + 25'(w_err);
    assign w_acc_z = (i_cfg.integral_reset_enable
                      && (w_err > i_cfg.integral_reset_threshold)) ? 25'sd0 : w_acc;
    assign w_ilim  = $signed({2'b00, i_cfg.integral_limit});

    always_comb begin
        if (w_acc_z > w_ilim) begin
            w_acc_c = w_ilim;
        end else if (w_acc_z < -w_ilim) begin
            w_acc_c = -w_ilim;
        end else begin
            w_acc_c = w_acc_z;
        end
    end

    assign w_esum_new = w_acc_c[23:0];

    assign w_prod_p_pos = 33'(w_kp) * 33'(w_err);
    assign w_prod_i_pos = 40'(w_ki) * 40'(w_esum_new);
    assign w_prod_d_pos = 34'(w_kd) * 34'(w_d1);

    assign w_v_pos = 42'(w_prod_p_pos >>> 8)
                   + 42'(w_prod_i_pos >>> 8)
                   + 42'(w_prod_d_pos >>> 8);

    assign w_v    = (i_cfg.form_select == pidd_pkg::FORM_POSITIONAL) ? w_v_pos : w_v_inc;
    assign w_olim = $signed({27'd0, i_cfg.output_limit});

    always_comb begin
        if (w_v > w_olim) begin
            w_v_c = w_olim;
            w_hit = 1'b1;
        end else if (w_v < -w_olim) begin
            w_v_c = -w_olim;
            w_hit = 1'b1;
        end else begin
            w_v_c = w_v;
            w_hit = 1'b0;
        end
    end

    always_comb begin
        o_state.prev_error      = w_err;
        o_state.prev_prev_error = i_state.prev_error;
        o_state.held_output     = w_v_c[15:0];
        if (i_cfg.form_select == pidd_pkg::FORM_POSITIONAL) begin
            o_state.error_sum = w_esum_new;
        end else begin
            o_state.error_sum = i_state.error_sum;
        end
        o_result.drive   = w_v_c[15:0];
        o_result.clamped = w_hit;
    end

endmodule

// ----- rtl/pid_controller_dual_form_core.sv -----
// ============================================================================
// pid_controller_dual_form_core
// Fixed-point PID controller with positional and incremental forms.
// ============================================================================
//
// Channel    Direction  Handshake                Payload
// ---------  ---------  -----------------------  ---------------------------
// in         input      i_in_valid / o_in_stall  i_in  (measured, setpoint)
// out        output     o_out_valid / i_out_stall o_out (drive, clamped)
// cfg        input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while o_in_stall is low; its result
// passes through the input register and then the result register.
// The rate is set by the combinational step between those registers, which
// also updates the error history, integral and held output.
// The synchronous active-low reset loads the register defaults and clears
// the controller state. A stall on the output holds the result register,
// and the input side stalls only while its register cannot move on.
//
module pid_controller_dual_form_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pidd_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pidd_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [pidd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pidd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pidd_pkg::t_cfg       r_cfg;
    pidd_pkg::t_pid_state r_state;
    pidd_pkg::t_pid_state n_state;
    pidd_pkg::t_in_item   r_in;
    logic                 r_in_valid;
    pidd_pkg::t_out_item  r_out;
    pidd_pkg::t_out_item  n_out;
    logic                 r_out_valid;
    logic                 w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pidd_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (pidd_pkg::t_reg_idx'(i_cfg_index))
                pidd_pkg::REG_GAIN_P:       r_cfg.gain_p <= i_cfg_data[15:0];
                pidd_pkg::REG_GAIN_I:       r_cfg.gain_i <= i_cfg_data[15:0];
                pidd_pkg::REG_GAIN_D:       r_cfg.gain_d <= i_cfg_data[15:0];
                pidd_pkg::REG_OUTPUT_LIMIT: r_cfg.output_limit <= i_cfg_data[14:0];
                pidd_pkg::REG_INTEG_LIMIT:  r_cfg.integral_limit <= i_cfg_data[22:0];
                pidd_pkg::REG_FORM_SELECT:  r_cfg.form_select <= i_cfg_data[0];
                pidd_pkg::REG_INTEG_RST_EN: r_cfg.integral_reset_enable <= i_cfg_data[0];
                pidd_pkg::REG_INTEG_RST_TH: r_cfg.integral_reset_threshold <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    pidd_datapath u_datapath (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidd_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule
